@@ rtl/core/csb_pkg.sv @@
// ----------------------------------------------------------------------------
// csb_pkg: shared types and constants for the cursor sequence buffer
// Request and response layouts, command and status codes, cell actions.
// ----------------------------------------------------------------------------
package csb_pkg;

	localparam int CSB_DEPTH = 32;
	localparam int CSB_IDX_W = $clog2(CSB_DEPTH);
	localparam int CSB_CNT_W = $clog2(CSB_DEPTH + 1);
	localparam int CSB_DATA_W = 64;

	// command codes (3-bit field; other codes are no-ops)
	localparam logic [2:0] MODE_REWIND  = 3'd0;
	localparam logic [2:0] MODE_ADVANCE = 3'd1;
	localparam logic [2:0] MODE_INSERT  = 3'd2;
	localparam logic [2:0] MODE_ATTACH  = 3'd3;
	localparam logic [2:0] MODE_REMOVE  = 3'd4;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// what one storage cell does this cycle
	typedef enum logic [1:0] {
		ACT_HOLD  = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_LEFT  = 2'd2,
		ACT_RIGHT = 2'd3
	} csb_act_t;

	typedef struct packed {
		logic [2:0]            mode;
		logic [CSB_DATA_W-1:0] entry_value;
	} csb_req_t;

	typedef struct packed {
		logic [1:0]            status;
		logic                  has_current;
		logic [CSB_DATA_W-1:0] current_value;
		logic [5:0]            item_count;
		logic [5:0]            cursor_position;
	} csb_rsp_t;

	// controller state seen by the top level
	typedef struct packed {
		logic [1:0]           status;
		logic [CSB_CNT_W-1:0] count;
		logic [CSB_CNT_W-1:0] cursor;
	} csb_state_t;

endpackage

@@ rtl/core/csb_cell.sv @@
// ----------------------------------------------------------------------------
// csb_cell: one entry slot of the list
// Holds, loads the new word, or takes the word of its lower or upper neighbour.
// ----------------------------------------------------------------------------
module csb_cell
	import csb_pkg::*;
(
	input  logic                  clk,
	input  csb_act_t              act,
	input  logic [CSB_DATA_W-1:0] load_value,
	input  logic [CSB_DATA_W-1:0] left_value,
	input  logic [CSB_DATA_W-1:0] right_value,
	output logic [CSB_DATA_W-1:0] value
);

	logic [CSB_DATA_W-1:0] value_q;

	always_ff @(posedge clk) begin
		unique case (act)
			ACT_LOAD:  value_q <= load_value;
			ACT_LEFT:  value_q <= left_value;
			ACT_RIGHT: value_q <= right_value;
			default:   value_q <= value_q;
		endcase
	end

	assign value = value_q;

endmodule

@@ rtl/core/csb_ctrl.sv @@
// ----------------------------------------------------------------------------
// csb_ctrl: cursor and count keeper
// Decodes a command, updates cursor and count, and steers every cell.
// ----------------------------------------------------------------------------
module csb_ctrl
	import csb_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [2:0] mode,
	output csb_act_t   act [CSB_DEPTH],
	output csb_state_t state
);

	logic [CSB_CNT_W-1:0] cursor_q, count_q;
	logic [1:0]           status_q;

	logic [CSB_CNT_W-1:0] cursor_d, count_d, cur_inc;
	logic [1:0]           status_d;
	logic [CSB_IDX_W-1:0] pos;
	logic                 has, full, open_gap, close_gap;

	assign has     = cursor_q < count_q;
	assign full    = count_q >= CSB_CNT_W'(CSB_DEPTH);
	assign cur_inc = cursor_q + CSB_CNT_W'(1);

	always_comb begin
		cursor_d  = cursor_q;
		count_d   = count_q;
		status_d  = ST_DONE;
		pos       = '0;
		open_gap  = 1'b0;
		close_gap = 1'b0;
		unique case (mode)
			MODE_REWIND: begin
				cursor_d = '0;
			end
			MODE_ADVANCE: begin
				if (has) begin
					cursor_d = cur_inc;
				end
			end
			MODE_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					pos      = has ? cursor_q[CSB_IDX_W-1:0] : '0;
					open_gap = 1'b1;
					cursor_d = CSB_CNT_W'(pos);
					count_d  = count_q + CSB_CNT_W'(1);
				end
			end
			MODE_ATTACH: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					// below full, cursor + 1 and count both fit an index
					pos      = has ? cur_inc[CSB_IDX_W-1:0] : count_q[CSB_IDX_W-1:0];
					open_gap = 1'b1;
					cursor_d = CSB_CNT_W'(pos);
					count_d  = count_q + CSB_CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (!has) begin
					status_d = ST_EMPTY;
				end else begin
					pos       = cursor_q[CSB_IDX_W-1:0];
					close_gap = 1'b1;
					count_d   = count_q - CSB_CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// slots above the count are don't-care, so the whole upper part shifts
	always_comb begin
		for (int i = 0; i < CSB_DEPTH; i++) begin
			act[i] = ACT_HOLD;
			if (accept && open_gap) begin
				if (CSB_IDX_W'(i) == pos) begin
					act[i] = ACT_LOAD;
				end else if (CSB_IDX_W'(i) > pos) begin
					act[i] = ACT_LEFT;
				end
			end else if (accept && close_gap) begin
				if (CSB_IDX_W'(i) >= pos) begin
					act[i] = ACT_RIGHT;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			count_q  <= '0;
			status_q <= ST_DONE;
		end else if (accept) begin
			cursor_q <= cursor_d;
			count_q  <= count_d;
			status_q <= status_d;
		end
	end

	assign state.status = status_q;
	assign state.count  = count_q;
	assign state.cursor = cursor_q;

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= count_q)
		else $error("cursor beyond count");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CSB_CNT_W'(CSB_DEPTH))
		else $error("count beyond depth");

	a_full_no_change: assert property (@(posedge clk) disable iff (!arst_n)
		$past(accept) && status_q == ST_FULL |-> $stable(count_q) && $stable(cursor_q))
		else $error("refused request changed the list");

endmodule

@@ rtl/core/cursor_sequence_buffer_core.sv @@
// ----------------------------------------------------------------------------
// cursor_sequence_buffer_core: ordered list of 64-bit entries with one cursor
// Chain of entry cells that shift as a row, with a cursor/count controller.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid, req_stall, req) carries a command and an entry
//   word: rewind, advance, insert before, attach after, remove current.
//   Response channel (rsp_valid, rsp_stall, rsp) returns one response per
//   request: status, current entry and its valid flag, count and cursor.
//   A request is taken at an edge where valid is high and stall is low.
// Operation:
//   First the command is applied: every cell of the row loads, holds or takes
//   a neighbour's word at once, so inserts and removes shift in one step.
//   Then the cell under the cursor is picked into the response register.
//   A new request is taken only after the cell update and the registered
//   cursor read of the last one are done.
// Reset:
//   arst_n empties the list and rewinds the cursor; cell contents are left
//   as they are and are never shown until written again.
// Back-pressure:
//   While rsp_stall holds a response, req_stall stays high, so at most one
//   request is in flight and no response is lost or repeated.
// ----------------------------------------------------------------------------
module cursor_sequence_buffer_core
	import csb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	input  csb_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	output csb_rsp_t rsp
);

	logic                  accept;
	logic                  pending_q;   // command applied, read still to do
	logic                  rsp_valid_q;
	csb_rsp_t              rsp_q;

	csb_act_t              act [CSB_DEPTH];
	csb_state_t            state;
	logic [CSB_DATA_W-1:0] cell_value [CSB_DEPTH];
	logic [CSB_DATA_W-1:0] cur_value;
	logic                  has_cur;

	// hold off while a request is in flight or its response is stuck
	assign req_stall = pending_q | (rsp_valid_q & rsp_stall);
	assign accept    = req_valid & ~req_stall;

	csb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.mode   (req.mode),
		.act    (act),
		.state  (state)
	);

	// the row: each cell sees its lower and upper neighbour
	for (genvar g = 0; g < CSB_DEPTH; g++) begin : g_cell
		logic [CSB_DATA_W-1:0] left_w, right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_inner_l
			assign left_w = cell_value[g-1];
		end
		if (g == CSB_DEPTH - 1) begin : g_last
			assign right_w = cell_value[g];
		end else begin : g_inner_r
			assign right_w = cell_value[g+1];
		end
		csb_cell u_cell (
			.clk         (clk),
			.act         (act[g]),
			.load_value  (req.entry_value),
			.left_value  (left_w),
			.right_value (right_w),
			.value       (cell_value[g])
		);
	end

	assign has_cur = state.cursor < state.count;

	// AND-OR pick of the cell under the cursor; zero when there is none
	always_comb begin
		cur_value = '0;
		for (int i = 0; i < CSB_DEPTH; i++) begin
			if (has_cur && state.cursor == CSB_CNT_W'(i)) begin
				cur_value = cur_value | cell_value[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pending_q <= accept;
			if (pending_q) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pending_q) begin
			rsp_q.status          <= state.status;
			rsp_q.has_current     <= has_cur;
			rsp_q.current_value   <= cur_value;
			rsp_q.item_count      <= 6'(state.count);
			rsp_q.cursor_position <= 6'(state.cursor);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |-> !rsp_valid_q)
		else $error("response register busy when read completes");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pending_q && req_stall)
		else $error("second request taken while one is in flight");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q |=> rsp_valid_q)
		else $error("applied request produced no response");

endmodule
